// ===== src/lbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbc_pkg
// shared types and constants of the block cache lookup
// ----------------------------------------------------------------------------
package lbc_pkg;

    localparam int ENTRIES      = 4;
    localparam int MAX_REQUEST  = 4096;
    localparam int IDX_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W        = $clog2(ENTRIES + 1);

    localparam int OFF_W        = 32;
    localparam int LEN_W        = 13;
    localparam int BLK_W        = 17;
    localparam int TAG_W        = 25;
    localparam int BOFF_W       = 16;
    localparam int SLOT_W       = 6;
    localparam int STAMP_W      = 64;
    localparam int DIV_STEPS    = OFF_W;
    localparam int DCNT_W       = $clog2(DIV_STEPS + 1);

    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam logic [BLK_W-1:0] DEFAULT_BLOCK = BLK_W'(65536);
    localparam logic [BLK_W-1:0] MIN_BLOCK     = BLK_W'(128);
    localparam logic [LEN_W-1:0] MAX_LEN       = LEN_W'(MAX_REQUEST);

    localparam logic REG_BLOCK_BYTES = 1'b0;
    localparam logic REG_TOTAL_BYTES = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [BLK_W-1:0]   fill;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic [BLK_W-1:0] block;
        logic [OFF_W-1:0] total;
        logic             flush;
    } cfg_t;

    typedef struct packed {
        logic              status;
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [TAG_W-1:0]  block_number;
        logic [BLK_W-1:0]  fill_bytes;
        logic [BOFF_W-1:0] chunk_offset;
        logic [LEN_W-1:0]  chunk_bytes;
        logic              last;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT
    } state_t;

endpackage

// ===== src/lbc_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbc_req_if
// read request channel
// ----------------------------------------------------------------------------
interface lbc_req_if;
    import lbc_pkg::*;

    logic             valid;
    logic             ready;
    logic [OFF_W-1:0] start_offset;
    logic [LEN_W-1:0] byte_count;

    modport source (output valid, output start_offset, output byte_count, input ready);
    modport sink   (input valid, input start_offset, input byte_count, output ready);
endinterface

// ===== src/lbc_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbc_rsp_if
// chunk result channel
// ----------------------------------------------------------------------------
interface lbc_rsp_if;
    import lbc_pkg::*;

    logic              valid;
    logic              ready;
    logic              status;
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [TAG_W-1:0]  block_number;
    logic [BLK_W-1:0]  fill_bytes;
    logic [BOFF_W-1:0] chunk_offset;
    logic [LEN_W-1:0]  chunk_bytes;
    logic              last;

    modport source (output valid, output status, output hit, output slot,
                    output block_number, output fill_bytes, output chunk_offset,
                    output chunk_bytes, output last, input ready);
    modport sink   (input valid, input status, input hit, input slot,
                    input block_number, input fill_bytes, input chunk_offset,
                    input chunk_bytes, input last, output ready);
endinterface

// ===== src/lbc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbc_cfg_regs
// apb register file for block size and file size, flush on every write
// ----------------------------------------------------------------------------
module lbc_cfg_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lbc_pkg::PADDR_W-1:0]  paddr,
    input  logic [lbc_pkg::PDATA_W-1:0]  pwdata,
    output logic [lbc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output lbc_pkg::cfg_t                cfg
);
    import lbc_pkg::*;

    logic [BLK_W-1:0] block_reg, block_next;
    logic [OFF_W-1:0] total_reg, total_next;
    logic             flush_reg, flush_next;
    logic             wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_comb
    begin
        block_next = block_reg;
        total_next = total_reg;
        flush_next = 1'b0;
        if (wr)
        begin
            flush_next = 1'b1;
            unique case (paddr[2])
                REG_BLOCK_BYTES: block_next = pwdata[BLK_W-1:0];
                REG_TOTAL_BYTES: total_next = pwdata;
                default:         block_next = block_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_BLOCK_BYTES: prdata = PDATA_W'(block_reg);
            REG_TOTAL_BYTES: prdata = total_reg;
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_reg <= DEFAULT_BLOCK;
            total_reg <= '0;
            flush_reg <= 1'b0;
        end
        else
        begin
            block_reg <= block_next;
            total_reg <= total_next;
            flush_reg <= flush_next;
        end
    end

    // zero or oversize means 64k, small values clamp up
    always_comb
    begin
        if (block_reg == '0 || block_reg > DEFAULT_BLOCK)
            cfg.block = DEFAULT_BLOCK;
        else if (block_reg < MIN_BLOCK)
            cfg.block = MIN_BLOCK;
        else
            cfg.block = block_reg;
        cfg.total = total_reg;
        cfg.flush = flush_reg;
    end
endmodule

// ===== src/lbc_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbc_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lbc_divider
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lbc_pkg::OFF_W-1:0]   dividend,
    input  logic [lbc_pkg::BLK_W-1:0]   divisor,
    output logic                        done,
    output logic [lbc_pkg::TAG_W-1:0]   quotient,
    output logic [lbc_pkg::BOFF_W-1:0]  remainder
);
    import lbc_pkg::*;

    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [OFF_W-1:0]  quo_reg, quo_next;
    logic [BLK_W-1:0]  rem_reg, rem_next;
    logic [BLK_W-1:0]  dvs_reg, dvs_next;
    logic [BLK_W:0]    trial;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[OFF_W-1]};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = BLK_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[OFF_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[BLK_W-1:0];
                quo_next = {quo_reg[OFF_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + DCNT_W'(1);
            if (cnt_reg == DCNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg[TAG_W-1:0];
    assign remainder = rem_reg[BOFF_W-1:0];
endmodule

// ===== src/lbc_entry_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbc_entry_ram
// entry store: tag, fill and stamp per slot, registered read
// ----------------------------------------------------------------------------
module lbc_entry_ram
(
    input  logic                        clk,
    input  logic                        we,
    input  logic [lbc_pkg::IDX_W-1:0]   waddr,
    input  lbc_pkg::entry_t             wdata,
    input  logic [lbc_pkg::IDX_W-1:0]   raddr,
    output lbc_pkg::entry_t             rdata
);
    import lbc_pkg::*;

    entry_t mem [ENTRIES];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== src/lru_block_cache_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_block_cache_lookup
// fully associative block cache lookup with least recently stamped eviction
//
//   channel | dir | handshake       | payload
//   req     | in  | valid / ready   | start_offset, byte_count
//   rsp     | out | valid / ready   | status .. last, one per block chunk
//   apb     | in  | psel / penable  | block_bytes @0, total_bytes @4
//
// a rejected or empty request goes from the bounds check straight to emit; else setup
// is a bounds check and a 32 step divide for block and offset, then each chunk
// takes a sequential scan of the entry ram, an update and an emit.
// one request is worked at a time; req.ready is high only when idle.
// reset empties all slots through the valid bits, no clearing pass.
// a held result stalls only the next chunk; the output register decouples rsp.
// ----------------------------------------------------------------------------
module lru_block_cache_lookup
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lbc_pkg::PADDR_W-1:0]  paddr,
    input  logic [lbc_pkg::PDATA_W-1:0]  pwdata,
    output logic [lbc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    lbc_req_if.sink                      req,
    lbc_rsp_if.source                    rsp
);
    import lbc_pkg::*;

    cfg_t              cfg;
    state_t            state_reg, state_next;

    logic [OFF_W-1:0]  off_reg, off_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [OFF_W-1:0]  base_reg, base_next;
    logic [TAG_W-1:0]  blk_reg, blk_next;
    logic [BOFF_W-1:0] boff_reg, boff_next;
    logic [BLK_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              hitf_reg, hitf_next;
    logic [IDX_W-1:0]  hidx_reg, hidx_next;
    logic [BLK_W-1:0]  hfill_reg, hfill_next;
    logic              empf_reg, empf_next;
    logic [IDX_W-1:0]  eidx_reg, eidx_next;
    logic [IDX_W-1:0]  midx_reg, midx_next;
    logic [STAMP_W-1:0] mstamp_reg, mstamp_next;
    logic [STAMP_W-1:0] clock_reg, clock_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic              more_reg, more_next;
    rsp_t              res_reg, res_next;
    rsp_t              rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    logic              div_start, div_done;
    logic [TAG_W-1:0]  div_quo;
    logic [BOFF_W-1:0] div_rem;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    entry_t            ram_wdata, ram_rdata;

    logic [IDX_W-1:0]  scan_idx;
    logic [OFF_W:0]    end_pos;
    logic [OFF_W-1:0]  remain;
    logic [BLK_W-1:0]  efill, avail;
    logic [LEN_W-1:0]  need;
    logic [IDX_W-1:0]  slot_sel;
    logic              emit_load;

    lbc_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lbc_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (off_reg),
        .divisor   (cfg.block),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    lbc_entry_ram u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign ram_raddr = cnt_reg[IDX_W-1:0];
    assign scan_idx  = IDX_W'(cnt_reg - CNT_W'(1));
    assign end_pos   = {1'b0, off_reg} + (OFF_W+1)'(len_reg);
    assign emit_load = (state_reg == ST_EMIT) && (!rsp_valid_reg || rsp.ready);

    // bytes of the block actually in the file
    always_comb
    begin
        remain = cfg.total - base_reg;
        if (remain > OFF_W'(cfg.block))
            fill_next = cfg.block;
        else
            fill_next = remain[BLK_W-1:0];
    end

    always_comb
    begin
        efill = hitf_reg ? hfill_reg : fill_reg;
        avail = efill - BLK_W'(boff_reg);
        if (BLK_W'(len_reg) > avail)
            need = avail[LEN_W-1:0];
        else
            need = len_reg;
        if (hitf_reg)
            slot_sel = hidx_reg;
        else if (empf_reg)
            slot_sel = eidx_reg;
        else
            slot_sel = midx_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        off_next       = off_reg;
        len_next       = len_reg;
        base_next      = base_reg;
        blk_next       = blk_reg;
        boff_next      = boff_reg;
        cnt_next       = cnt_reg;
        hitf_next      = hitf_reg;
        hidx_next      = hidx_reg;
        hfill_next     = hfill_reg;
        empf_next      = empf_reg;
        eidx_next      = eidx_reg;
        midx_next      = midx_reg;
        mstamp_next    = mstamp_reg;
        clock_next     = clock_reg;
        valid_next     = valid_reg;
        more_next      = more_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        div_start      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = slot_sel;
        ram_wdata.tag  = blk_reg;
        ram_wdata.fill = efill;
        ram_wdata.stamp = clock_reg + STAMP_W'(1);

        if (emit_load)
            rsp_next = res_reg;
        if (emit_load)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    off_next   = req.start_offset;
                    len_next   = req.byte_count;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                res_next      = '0;
                res_next.last = 1'b1;
                more_next     = 1'b0;
                if (len_reg > MAX_LEN || end_pos > (OFF_W+1)'(cfg.total))
                begin
                    res_next.status = STATUS_RANGE;
                    state_next      = ST_EMIT;
                end
                else if (len_reg == '0)
                begin
                    res_next.status = STATUS_OK;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    blk_next    = div_quo;
                    boff_next   = div_rem;
                    base_next   = off_reg - OFF_W'(div_rem);
                    cnt_next    = '0;
                    hitf_next   = 1'b0;
                    empf_next   = 1'b0;
                    midx_next   = '0;
                    mstamp_next = '1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg != '0)
                begin
                    if (valid_reg[scan_idx])
                    begin
                        if (!hitf_reg && ram_rdata.tag == blk_reg)
                        begin
                            hitf_next  = 1'b1;
                            hidx_next  = scan_idx;
                            hfill_next = ram_rdata.fill;
                        end
                        if (ram_rdata.stamp < mstamp_reg)
                        begin
                            mstamp_next = ram_rdata.stamp;
                            midx_next   = scan_idx;
                        end
                    end
                    else if (!empf_reg)
                    begin
                        empf_next = 1'b1;
                        eidx_next = scan_idx;
                    end
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(ENTRIES))
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                ram_we                = 1'b1;
                valid_next[slot_sel]  = 1'b1;
                clock_next            = clock_reg + STAMP_W'(1);
                res_next.status       = STATUS_OK;
                res_next.hit          = hitf_reg;
                res_next.slot         = SLOT_W'(slot_sel);
                res_next.block_number = blk_reg;
                res_next.fill_bytes   = hitf_reg ? '0 : fill_reg;
                res_next.chunk_offset = boff_reg;
                res_next.chunk_bytes  = need;
                res_next.last         = (need == len_reg);
                more_next             = (need != len_reg);
                len_next              = len_reg - need;
                blk_next              = blk_reg + TAG_W'(1);
                boff_next             = '0;
                base_next             = base_reg + OFF_W'(cfg.block);
                state_next            = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    if (more_reg)
                    begin
                        cnt_next    = '0;
                        hitf_next   = 1'b0;
                        empf_next   = 1'b0;
                        midx_next   = '0;
                        mstamp_next = '1;
                        state_next  = ST_SCAN;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        if (cfg.flush)
            valid_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            hitf_reg      <= 1'b0;
            empf_reg      <= 1'b0;
            clock_reg     <= '0;
            valid_reg     <= '0;
            more_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            hitf_reg      <= hitf_next;
            empf_reg      <= empf_next;
            clock_reg     <= clock_next;
            valid_reg     <= valid_next;
            more_reg      <= more_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg    <= off_next;
        len_reg    <= len_next;
        base_reg   <= base_next;
        blk_reg    <= blk_next;
        boff_reg   <= boff_next;
        fill_reg   <= fill_next;
        hidx_reg   <= hidx_next;
        hfill_reg  <= hfill_next;
        eidx_reg   <= eidx_next;
        midx_reg   <= midx_next;
        mstamp_reg <= mstamp_next;
        res_reg    <= res_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_reg.status;
    assign rsp.hit          = rsp_reg.hit;
    assign rsp.slot         = rsp_reg.slot;
    assign rsp.block_number = rsp_reg.block_number;
    assign rsp.fill_bytes   = rsp_reg.fill_bytes;
    assign rsp.chunk_offset = rsp_reg.chunk_offset;
    assign rsp.chunk_bytes  = rsp_reg.chunk_bytes;
    assign rsp.last         = rsp_reg.last;
endmodule
